FILE: hdl/layer_norm_row_assert.svh
// ----------------------------------------------------------------------------
// layer_norm_row assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef LAYER_NORM_ROW_ASSERT_SVH
`define LAYER_NORM_ROW_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LNR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("layer_norm_row port check failed");

// next-cycle implication, checked out of reset
`define LNR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("layer_norm_row port check failed");

`endif

FILE: hdl/lnr_pkg.sv
// ----------------------------------------------------------------------------
// lnr_pkg
// Types and constants shared by the row normalizer modules.
// ----------------------------------------------------------------------------
package lnr_pkg;

    // stored element: value, gain, bias (Q8.8 each)
    typedef struct packed {
        logic signed [15:0] bias;
        logic signed [15:0] gain;
        logic signed [15:0] x;
    } entry_t;

    // handshake between the sequencer and a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_VAR_RD,
        ST_VAR_DIF,
        ST_VAR_SQ,
        ST_VAR_ACC,
        ST_VDIV_GO,
        ST_VDIV_WAIT,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_OUT_RD,
        ST_OUT_DIF,
        ST_OUT_M1,
        ST_OUT_M2,
        ST_OUT_Y
    } state_t;

    // register map
    localparam logic [1:0] ADDR_EPSILON = 2'd0;
    localparam logic [15:0] EPSILON_RST = 16'd1;

    // datapath widths fixed by the Q8.8 fields
    localparam int MEAN_W = 24;              // mean, LSB 2^-16
    localparam int DIFF_W = 26;              // x*2^8 - mean
    localparam int SQ_W   = 49;              // diff^2 magnitude
    localparam int DVD_W  = 65;              // divider dividend width
    localparam int INV_W  = 33;              // inverse std, LSB 2^-16
    localparam int RT_IN_W  = 64;
    localparam int RT_OUT_W = 32;

    localparam logic [DVD_W-1:0] RECIP_NUM = {1'b1, {(DVD_W-1){1'b0}}};   // 2^64
    localparam logic [INV_W-1:0] INV_SAT   = {1'b1, {(INV_W-1){1'b0}}};   // 2^32

endpackage

FILE: hdl/lnr_store.sv
// ----------------------------------------------------------------------------
// lnr_store
// Row buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lnr_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  lnr_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output lnr_pkg::entry_t  rd_data
);
    import lnr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lnr_divider.sv
// ----------------------------------------------------------------------------
// lnr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnr_divider #(
    parameter int DVS_W = 56
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [lnr_pkg::DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]           divisor,
    output lnr_pkg::unit_status_t      status,
    output logic [lnr_pkg::DVD_W-1:0]  quotient,
    output logic [DVS_W-1:0]           remainder
);
    import lnr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // shift one dividend bit into the partial remainder
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status    = '{busy: busy_reg, done: done_reg};
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/lnr_isqrt.sv
// ----------------------------------------------------------------------------
// lnr_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module lnr_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lnr_pkg::RT_IN_W-1:0]   operand,
    output lnr_pkg::unit_status_t         status,
    output logic [lnr_pkg::RT_OUT_W-1:0]  root
);
    import lnr_pkg::*;

    localparam int CNT_W = $clog2(RT_OUT_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RT_IN_W-1:0] val_reg, val_next;
    logic [RT_IN_W-1:0] res_reg, res_next;
    logic [RT_IN_W-1:0] bit_reg, bit_next;
    logic [RT_IN_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = operand;
            res_next  = '0;
            bit_next  = {2'b01, {(RT_IN_W-2){1'b0}}};
        end else if (busy_reg) begin
            // try setting this root bit
            if (val_reg >= trial) begin
                val_next = val_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(RT_OUT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        val_reg <= val_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign root   = res_reg[RT_OUT_W-1:0];

endmodule

FILE: hdl/layer_norm_row.sv
// ----------------------------------------------------------------------------
// layer_norm_row
// Fixed-point layer normalization of one buffered row.
// ----------------------------------------------------------------------------
// Input beats (s_ channel) carry one row element: value, gain and bias in
// signed Q8.8, with tlast on the final element. A beat arriving while
// MAX_ROW elements are already buffered is dropped and ends the row.
// Once the row ends, s_tready stays low while the block computes the mean
// (serial divide), the variance pass (read, difference, square and
// accumulate per element), the variance divide, the reciprocal divide
// and the square root; when the variance is 0 or 1 both of the last two
// are skipped. It then emits one output beat per element, tlast on the
// final one, finishing each element before it reads the next; the serial
// divider and the single row-buffer read port set the pace of a row.
// A stalled m_ channel holds the output register and pauses the output pass.
// epsilon is written over the APB port (Q0.16, reset value 2^-16).
// Reset (synchronous, active low) empties the row and drops any result.
// ----------------------------------------------------------------------------
module layer_norm_row #(
    parameter int MAX_ROW = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // element stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] x_value, [31:16] gain, [47:32] bias
    input  logic        s_tlast,   // last_of_row
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] y_value
    output logic        m_tlast    // last_out
);
    import lnr_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROW + 1);
    localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int SUM_W = 17 + $clog2(MAX_ROW);
    localparam int MX_W  = SUM_W + 8;
    localparam int ACC_W = SQ_W + $clog2(MAX_ROW);
    localparam int VAR_W = ACC_W + 1;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] eps_reg;
    logic        cfg_wr;

    // row bookkeeping
    logic [CNT_W-1:0]        count_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    idx_last;
    logic                    s_beat;
    logic                    row_full;

    // datapath registers
    logic signed [MEAN_W-1:0] mean_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [VAR_W-1:0]         var_reg;
    logic [INV_W-1:0]         inv_reg;
    logic signed [59:0]       p1_reg;
    logic signed [59:0]       p2_reg;
    logic [15:0]              y_reg;
    logic                     last_reg;
    logic                     out_valid_reg;

    // store ports
    logic             mem_we;
    logic             mem_re;
    entry_t           mem_wdata;
    entry_t           mem_rdata;

    // divider and root ports
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [VAR_W-1:0]   div_dvs;
    unit_status_t       div_st;
    logic [DVD_W-1:0]   div_quo;
    logic [VAR_W-1:0]   div_rem;
    logic               rt_start;
    unit_status_t       rt_st;
    logic [RT_OUT_W-1:0] rt_root;

    // combinational arithmetic
    logic signed [MX_W-1:0]   sum_x256;
    logic [MX_W-1:0]          sum_mag;
    logic signed [MX_W:0]     mean_full;
    logic signed [DIFF_W-1:0] diff_comb;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic signed [43:0]       norm;
    logic signed [59:0]       t_full;
    logic signed [43:0]       y_full;
    logic [15:0]              y_sat;
    logic                     out_load;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_EPSILON);
    assign prdata = (paddr == ADDR_EPSILON) ? {16'd0, eps_reg} : 32'd0;

    assign s_beat   = s_tvalid && s_tready;
    assign row_full = (count_reg == CNT_W'(MAX_ROW));
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    assign mem_wdata = '{bias: s_tdata[47:32], gain: s_tdata[31:16], x: s_tdata[15:0]};

    lnr_store #(
        .DEPTH (MAX_ROW),
        .AW    (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (idx_reg),
        .rd_data (mem_rdata)
    );

    lnr_divider #(
        .DVS_W (VAR_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .status    (div_st),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    lnr_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rt_start),
        .operand (div_quo[RT_IN_W-1:0]),
        .status  (rt_st),
        .root    (rt_root)
    );

    // mean operands: |sum * 2^8| / n, floor fix-up for negative sums
    assign sum_x256  = {sum_reg, 8'd0};
    assign sum_mag   = sum_reg[SUM_W-1] ? MX_W'(-sum_x256) : MX_W'(sum_x256);
    assign mean_full = sum_reg[SUM_W-1]
        ? ((div_rem != '0) ? -$signed({1'b0, div_quo[MX_W-1:0]}) - (MX_W+1)'(1)
                           : -$signed({1'b0, div_quo[MX_W-1:0]}))
        : $signed({1'b0, div_quo[MX_W-1:0]});

    // element arithmetic
    assign diff_comb = $signed({{2{mem_rdata.x[15]}}, mem_rdata.x, 8'd0})
                     - $signed({{(DIFF_W-MEAN_W){mean_reg[MEAN_W-1]}}, mean_reg});
    assign sq_full   = diff_reg * diff_reg;
    assign norm      = p1_reg[59:16];
    assign t_full    = p2_reg + $signed({{28{mem_rdata.bias[15]}}, mem_rdata.bias, 16'd0});
    assign y_full    = t_full[59:16];

    always_comb begin
        if (y_full > 44'sd32767) begin
            y_sat = 16'h7fff;
        end else if (y_full < -44'sd32768) begin
            y_sat = 16'h8000;
        end else begin
            y_sat = y_full[15:0];
        end
    end

    assign out_load = (state_reg == ST_OUT_Y) && (!out_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_beat && (row_full || s_tlast)) begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_VAR_RD;
                end
            end
            ST_VAR_RD:  state_next = ST_VAR_DIF;
            ST_VAR_DIF: state_next = ST_VAR_SQ;
            ST_VAR_SQ:  state_next = ST_VAR_ACC;
            ST_VAR_ACC: state_next = idx_last ? ST_VDIV_GO : ST_VAR_RD;
            ST_VDIV_GO: state_next = ST_VDIV_WAIT;
            ST_VDIV_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_RDIV_GO;
                end
            end
            ST_RDIV_GO: state_next = (var_reg <= VAR_W'(1)) ? ST_OUT_RD : ST_RDIV_WAIT;
            ST_RDIV_WAIT: begin
                if (div_st.done) begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (rt_st.done) begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:  state_next = ST_OUT_DIF;
            ST_OUT_DIF: state_next = ST_OUT_M1;
            ST_OUT_M1:  state_next = ST_OUT_M2;
            ST_OUT_M2:  state_next = ST_OUT_Y;
            ST_OUT_Y: begin
                if (out_load) begin
                    state_next = idx_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        div_dvd   = DVD_W'(sum_mag);
        div_dvs   = VAR_W'(count_reg);
        rt_start  = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                mem_we   = s_tvalid && !row_full;
            end
            ST_MEAN_GO: div_start = 1'b1;
            ST_VAR_RD:  mem_re = 1'b1;
            ST_OUT_RD:  mem_re = 1'b1;
            ST_VDIV_GO: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(acc_reg);
            end
            ST_RDIV_GO: begin
                div_start = (var_reg > VAR_W'(1));
                div_dvd   = RECIP_NUM;
                div_dvs   = var_reg;
            end
            ST_SQRT_GO: rt_start = 1'b1;
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            eps_reg       <= EPSILON_RST;
            count_reg     <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                eps_reg <= pwdata[15:0];
            end
            // row fill
            if (mem_we && s_beat) begin
                count_reg <= count_reg + CNT_W'(1);
                sum_reg   <= sum_reg + SUM_W'($signed(s_tdata[15:0]));
            end
            // element index for both passes
            if (state_reg == ST_VAR_ACC) begin
                idx_reg <= idx_last ? '0 : idx_reg + IDX_W'(1);
            end else if (out_load) begin
                idx_reg <= idx_last ? '0 : idx_reg + IDX_W'(1);
                if (idx_last) begin
                    count_reg <= '0;
                    sum_reg   <= '0;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MEAN_WAIT && div_st.done) begin
            mean_reg <= mean_full[MEAN_W-1:0];
        end
        if (state_reg == ST_MEAN_GO) begin
            acc_reg <= '0;
        end else if (state_reg == ST_VAR_ACC) begin
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        end
        if (state_reg == ST_VAR_DIF || state_reg == ST_OUT_DIF) begin
            diff_reg <= diff_comb;
        end
        if (state_reg == ST_VAR_SQ) begin
            sq_reg <= sq_full[SQ_W-1:0];
        end
        if (state_reg == ST_VDIV_WAIT && div_st.done) begin
            var_reg <= VAR_W'(div_quo[ACC_W-1:0]) + (VAR_W'(eps_reg) << 16);
        end
        if (state_reg == ST_RDIV_GO && var_reg <= VAR_W'(1)) begin
            inv_reg <= INV_SAT;
        end else if (state_reg == ST_SQRT_WAIT && rt_st.done) begin
            inv_reg <= INV_W'(rt_root);
        end
        if (state_reg == ST_OUT_M1) begin
            p1_reg <= diff_reg * $signed({1'b0, inv_reg});
        end
        if (state_reg == ST_OUT_M2) begin
            // full 60-bit product, sized by the target
            p2_reg <= norm * mem_rdata.gain;
        end
        if (out_load) begin
            y_reg    <= y_sat;
            last_reg <= idx_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = y_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: hdl/lnr_checker.sv
// ----------------------------------------------------------------------------
// lnr_checker
// Port-level checks on the row normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "layer_norm_row_assert.svh"

module lnr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    `LNR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast}))

    // closing a row stops intake while the row is processed
    `LNR_ASSERT_NEXT(a_row_close, s_tvalid && s_tready && s_tlast, !s_tready)

    // nothing follows the row's final result right away
    `LNR_ASSERT_NEXT(a_row_end, m_tvalid && m_tready && m_tlast, !m_tvalid)

    // an idle output stays idle while the row keeps loading
    `LNR_ASSERT_NOW(a_no_out_in_fill, s_tready && $past(s_tready) && !$past(m_tvalid), !m_tvalid)

endmodule

bind layer_norm_row lnr_checker u_lnr_checker (.*);

FILE: test/layer_norm_row_check.sv
// ----------------------------------------------------------------------------
// layer_norm_row_check
// Watches the config port and both streams of the row normalizer, keeps
// its own copy of the row buffer and epsilon, predicts every output beat
// and compares each beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layer_norm_row_check #(
    parameter int ROW_CAP = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] x_value, [31:16] gain, [47:32] bias
    input  logic        s_tlast,   // last_of_row
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] y_value
    input  logic        m_tlast,   // last_out
    output int          fail_count,
    output int          results_owed
);
    import lnr_pkg::*;

    typedef struct {
        logic signed [15:0] y_value;
        logic               last_out;
    } norm_result_t;

    norm_result_t       owed_q[$];
    logic signed [15:0] row_x [ROW_CAP];
    logic signed [15:0] row_gain [ROW_CAP];
    logic signed [15:0] row_bias [ROW_CAP];
    int                 row_len;
    longint             row_sum;
    logic [15:0]        eps_reg;

    // floor(2^32 / sqrt(v)), held at 2^32 for v <= 1
    function automatic longint inv_std_of(longint unsigned v);
        logic [64:0] quot;
        logic [65:0] lo, hi, mid;
        if (v <= 1)
            return 64'h1_0000_0000;
        quot = (65'h1 << 64) / v;
        lo = 0;
        hi = 66'h1_0000_0000;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= quot)
                lo = mid;
            else
                hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    // close the buffered row: queue one result per element
    task automatic normalize_row();
        longint          mean, diff, inv, norm, t, y;
        longint unsigned sumsq, var_q32;
        norm_result_t    r;
        if (row_len == 0)
            return;
        mean = (row_sum * 256) / row_len;
        if (((row_sum * 256) % row_len) != 0 && row_sum < 0)
            mean = mean - 1;
        sumsq = 0;
        for (int i = 0; i < row_len; i++) begin
            diff = longint'(row_x[i]) * 256 - mean;
            sumsq += longint'(diff * diff);
        end
        var_q32 = sumsq / row_len + (longint'(eps_reg) << 16);
        inv = inv_std_of(var_q32);
        for (int i = 0; i < row_len; i++) begin
            diff = longint'(row_x[i]) * 256 - mean;
            norm = (diff * inv) >>> 16;
            t = norm * longint'(row_gain[i]) + longint'(row_bias[i]) * 65536;
            y = t >>> 16;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            r.y_value = y[15:0];
            r.last_out = (i + 1 == row_len);
            owed_q.push_back(r);
        end
        row_len = 0;
        row_sum = 0;
    endtask

    always @(posedge aclk) begin
        norm_result_t got, want;
        if (!aresetn) begin
            owed_q.delete();
            row_len = 0;
            row_sum = 0;
            eps_reg = EPSILON_RST;
            fail_count = 0;
        end else begin
            // register write
            if (psel && penable && pwrite && pready && paddr == ADDR_EPSILON)
                eps_reg = pwdata[15:0];

            // input beat: a beat on a full buffer is dropped and ends the row
            if (s_tvalid && s_tready) begin
                if (row_len >= ROW_CAP) begin
                    normalize_row();
                end else begin
                    row_x[row_len] = s_tdata[15:0];
                    row_gain[row_len] = s_tdata[31:16];
                    row_bias[row_len] = s_tdata[47:32];
                    row_sum += longint'($signed(s_tdata[15:0]));
                    row_len++;
                    if (s_tlast)
                        normalize_row();
                end
            end

            // output beat
            if (m_tvalid && m_tready) begin
                got.y_value = m_tdata;
                got.last_out = m_tlast;
                if (owed_q.size() == 0) begin
                    $error("unexpected output beat: y_value %0d last_out %0b",
                           got.y_value, got.last_out);
                    fail_count++;
                end else begin
                    want = owed_q.pop_front();
                    if (got.y_value !== want.y_value) begin
                        $error("y_value mismatch: expected %0d actual %0d",
                               want.y_value, got.y_value);
                        fail_count++;
                    end
                    if (got.last_out !== want.last_out) begin
                        $error("last_out mismatch: expected %0b actual %0b",
                               want.last_out, got.last_out);
                        fail_count++;
                    end
                end
            end
        end
        results_owed = owed_q.size();
    end

endmodule

FILE: test/layer_norm_row_test.sv
// ----------------------------------------------------------------------------
// layer_norm_row_test
// Drives rows of elements and epsilon settings into the row normalizer:
// a directed set of edge rows, then random rows under three idling mixes,
// a long output hold-off and a full drain. Checking lives in the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module layer_norm_row_test;
    import lnr_pkg::*;

    localparam int ROW_CAP = 64;
    localparam int CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [15:0] x_value, [31:16] gain, [47:32] bias
    logic        s_tlast = 1'b0; // last_of_row
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [15:0] y_value
    logic        m_tlast;        // last_out

    int fail_count, results_owed;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_cycles = 0;
    logic hold_req = 1'b0;
    int cycle_count = 0;
    int elems_sent = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    layer_norm_row #(.MAX_ROW(ROW_CAP)) u_dut (.*);

    layer_norm_row_check #(.ROW_CAP(ROW_CAP)) u_check (.*);

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_cycles <= 700;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("layer_norm_row verification failed");
            $finish;
        end
    end

    task automatic write_epsilon(input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_EPSILON;
        pwdata <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one element beat, with random idle cycles ahead of it
    task automatic send_elem(input logic [15:0] x, input logic [15:0] g,
                             input logic [15:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, x};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        elems_sent++;
    endtask

    // wait for every owed result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_q88(input int narrow);
        if (narrow)
            return 16'($urandom_range(0, 2047)) - 16'd1024;
        return 16'($urandom());
    endfunction

    // random row; overlong rows end on a dropped extra beat
    task automatic send_random_row(input int len, input int overlong);
        int narrow;
        narrow = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < len; i++)
            send_elem(rand_q88(narrow), rand_q88(narrow), rand_q88(narrow),
                      !overlong && (i == len - 1));
        if (overlong)
            send_elem(rand_q88(0), rand_q88(0), rand_q88(0), 1'($urandom()));
    endtask

    task automatic random_phase(input int n_elems);
        int len, pick;
        int start_count;
        start_count = elems_sent;
        while (elems_sent - start_count < n_elems) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = ROW_CAP;
            else if (pick < 4)
                len = $urandom_range(9, 24);
            else
                len = $urandom_range(1, 8);
            send_random_row(len, (pick == 0) && $urandom_range(0, 1));
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: lone element at reset epsilon
        send_elem(16'sd32767, 16'sd32767, 16'sd0, 1'b1);
        drain();

        // zero epsilon: zero variance rows
        write_epsilon(16'd0);
        send_elem(16'h8000, 16'h7fff, 16'h8000, 1'b1);
        send_elem(16'h8000, 16'h0100, 16'h7fff, 1'b0);
        send_elem(16'h8000, 16'h8000, 16'h0001, 1'b1);
        // extremes of every field
        send_elem(16'h8000, 16'h7fff, 16'h8000, 1'b0);
        send_elem(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
        send_elem(16'h0000, 16'h0100, 16'h0000, 1'b0);
        send_elem(16'h0001, 16'hffff, 16'hffff, 1'b1);
        drain();

        // largest epsilon
        write_epsilon(16'hffff);
        send_elem(16'h0100, 16'h0100, 16'h0000, 1'b0);
        send_elem(16'hff00, 16'h7fff, 16'h0080, 1'b0);
        send_elem(16'h0000, 16'h8000, 16'hff80, 1'b1);
        drain();

        // random phase one: sender rarely idles, receiver mostly stalls
        write_epsilon(16'($urandom_range(1, 300)));
        send_idle_pct = 8;
        recv_stall_pct = 87;
        random_phase(40);
        drain();

        // random phase two: the other way round, plus a long output hold-off
        write_epsilon(16'd0);
        send_idle_pct = 87;
        recv_stall_pct = 8;
        send_random_row(4, 0);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        send_idle_pct = 0;
        send_random_row(ROW_CAP, 1);
        send_idle_pct = 87;
        random_phase(20);
        drain();

        // random phase three: no idling
        write_epsilon(16'($urandom()));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(40);
        drain();

        repeat (50) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("layer_norm_row verification clean");
        end else begin
            $display("layer_norm_row verification failed");
        end
        $finish;
    end

endmodule
